/* hdl/dbscan_pkg.sv */
package dbscan_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int EPS_W  = 33;
  localparam int MINN_W = 6;
  localparam int ID_W   = 6;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_EPS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINN = 1'd1;
  localparam logic [EPS_W-1:0]  EPS_RST  = 33'd256;
  localparam logic [MINN_W-1:0] MINN_RST = 6'd4;

  typedef struct packed {
    logic       vld;
    logic [5:0] cid;
    logic [5:0] idx;
    logic       eoc;
    logic       eoa;
    logic       none;
  } res_ctl_t;

endpackage

/* hdl/dbscan_ram.sv */
module dbscan_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hdl/dbscan_dist.sv */
// Two-stage squared distance test: subtract and square, then sum and compare.
module dbscan_dist #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic [dbscan_pkg::EPS_W-1:0] eps,
  output logic                         near
);
  localparam int DW = COORD_BITS + 1;
  localparam int SW = 2 * DW;
  localparam int CMPW = (SW + 1 > dbscan_pkg::EPS_W) ? SW + 1 : dbscan_pkg::EPS_W;
  logic signed [DW-1:0] dx, dy;
  logic signed [SW-1:0] qx, qy;
  logic [SW-1:0] sx_r, sy_r;
  logic [SW:0]   d2;
  always_comb begin
    dx = DW'(ax) - DW'(bx);
    dy = DW'(ay) - DW'(by);
    qx = dx * dx;
    qy = dy * dy;
    d2 = (SW+1)'(sx_r) + (SW+1)'(sy_r);
  end
  always_ff @(posedge clk) begin
    sx_r <= $unsigned(qx);
    sy_r <= $unsigned(qy);
  end
  assign near = (d2 != '0) && (CMPW'(d2) <= CMPW'(eps));
endmodule

/* hdl/dbscan_point_clustering.sv */
// Channel | Dir | Fields (tdata low bit up)                     | Handshake
// in_     | in  | coord_x, coord_y; tlast = last_point          | tvalid/tready
// out_    | out | cluster_id, point_index, out_x, out_y,        | tvalid/tready
//         |     | tuser = {overflow, no_clusters, end_of_cluster}, tlast = end_of_all
// cfg_    | in  | eps_squared (0), min_neighbors (1)            | cfg_we
// Loading accepts one point per cycle. Clustering then walks the point memory
// through one read port: each core test or neighbour scan of a point reads
// every stored point in turn, with bookkeeping states between the scans.
// Reset is synchronous; marks are flip-flops cleared when a cloud is finished.
// A stalled result holds the walk until it is taken.
module dbscan_point_clustering #(
  parameter int MAX_POINTS = dbscan_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = dbscan_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] in_tdata,  // coord_x, coord_y
  input  logic in_tlast,                                // last_point
  output logic out_tvalid,
  input  logic out_tready,
  output logic [((12+2*COORD_BITS+7)/8)*8-1:0] out_tdata, // cluster_id, point_index, out_x, out_y
  output logic [2:0] out_tuser,                         // end_of_cluster, no_clusters, overflow
  output logic out_tlast,                               // end_of_all
  input  logic cfg_we,
  input  logic [dbscan_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbscan_pkg::EPS_W-1:0]     cfg_data
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;
  localparam int OW = ((12+2*COORD_BITS+7)/8)*8;
  localparam int PW = 2 * COORD_BITS;

  localparam logic [3:0] S_LOAD = 4'd0, S_OUTER = 4'd1, S_RD = 4'd2, S_SEED = 4'd3,
                         S_EMIT = 4'd4, S_CORE = 4'd5, S_NB = 4'd6, S_POP = 4'd7,
                         S_POPRD = 4'd8, S_FIN = 4'd9;

  logic [dbscan_pkg::EPS_W-1:0]  eps_r;
  logic [dbscan_pkg::MINN_W-1:0] minn_r;
  logic [3:0]    st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [5:0]    cid_r, cid_nxt;
  logic [CW-1:0] outer_r, outer_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic          mem_r, mem_nxt;
  logic [PW-1:0] cur_xy_r, cur_xy_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [CW-1:0] nb_r, nb_nxt;
  logic [MAX_POINTS-1:0] clus_r, clus_nxt, qd_r, qd_nxt;
  logic [CW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  dbscan_pkg::res_ctl_t hold_r, hold_nxt, res_r, res_nxt;
  logic [PW-1:0] hxy_r, hxy_nxt, oxy_r, oxy_nxt;
  logic          oovf_r, oovf_nxt;
  logic          p_r, pp_r;
  logic [AW-1:0] pi_r, ppi_r;

  logic          pt_we, q_we;
  logic [AW-1:0] pt_wa, pt_ra, q_wa, q_ra;
  logic [PW-1:0] pt_wd, pt_rd;
  logic [AW-1:0] q_rd;
  logic          near;

  dbscan_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pts (
    .clk, .we(pt_we), .waddr(pt_wa), .wdata(pt_wd), .raddr(pt_ra), .rdata(pt_rd));
  dbscan_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_q (
    .clk, .we(q_we), .waddr(q_wa), .wdata(ppi_r), .raddr(q_ra), .rdata(q_rd));

  dbscan_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk, .ax(cur_xy_r[COORD_BITS-1:0]), .ay(cur_xy_r[PW-1:COORD_BITS]),
    .bx(pt_rd[COORD_BITS-1:0]), .by(pt_rd[PW-1:COORD_BITS]), .eps(eps_r), .near);

  wire in_acc    = in_tvalid && in_tready;
  wire out_acc   = out_tvalid && out_tready;
  assign in_tready = (st_r == S_LOAD);
  wire scan_busy = (scan_r < cnt_r);
  wire scan_done = !scan_busy && !p_r && !pp_r;
  wire issue     = (st_r == S_CORE || st_r == S_NB) && scan_busy;
  wire out_free  = !res_r.vld || out_acc;
  wire is_core   = (int'(nb_r) >= int'(minn_r));
  wire q_hit     = (st_r == S_NB) && pp_r && near && !qd_r[ppi_r] && !clus_r[ppi_r];

  assign pt_we = in_acc && (cnt_r < CW'(MAX_POINTS));
  assign pt_wa = cnt_r[AW-1:0];
  assign pt_wd = in_tdata[PW-1:0];
  assign pt_ra = (st_r == S_RD) ? cur_r : scan_r[AW-1:0];
  assign q_we  = q_hit;
  assign q_wa  = tail_r[AW-1:0];
  assign q_ra  = head_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= dbscan_pkg::EPS_RST;
      minn_r <= dbscan_pkg::MINN_RST;
    end else if (cfg_we) begin
      if (cfg_index == dbscan_pkg::REG_EPS) eps_r <= cfg_data;
      else if (cfg_index == dbscan_pkg::REG_MINN) minn_r <= cfg_data[dbscan_pkg::MINN_W-1:0];
    end
  end

  // scan pipeline: address issued, data read, distance registered
  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; ovf_nxt = ovf_r; cid_nxt = cid_r;
    outer_nxt = outer_r; cur_nxt = cur_r; mem_nxt = mem_r; cur_xy_nxt = cur_xy_r;
    scan_nxt = scan_r; nb_nxt = nb_r; clus_nxt = clus_r; qd_nxt = qd_r;
    head_nxt = head_r; tail_nxt = tail_r; hold_nxt = hold_r; hxy_nxt = hxy_r;
    res_nxt = res_r; oxy_nxt = oxy_r; oovf_nxt = oovf_r;
    if (out_acc) res_nxt.vld = 1'b0;
    case (st_r)
      S_LOAD: if (in_acc) begin
        if (cnt_r < CW'(MAX_POINTS)) cnt_nxt = cnt_r + 1'b1;
        else ovf_nxt = 1'b1;
        if (in_tlast) begin
          outer_nxt = '0; st_nxt = S_OUTER;
        end
      end
      S_OUTER: begin
        if (outer_r >= cnt_r) st_nxt = S_FIN;
        else if (clus_r[outer_r[AW-1:0]]) outer_nxt = outer_r + 1'b1;
        else begin
          cur_nxt = outer_r[AW-1:0]; mem_nxt = 1'b0; st_nxt = S_RD;
        end
      end
      S_RD: st_nxt = S_SEED;
      S_SEED: begin
        cur_xy_nxt = pt_rd; scan_nxt = '0; nb_nxt = '0;
        st_nxt = mem_r ? S_EMIT : S_CORE;
      end
      S_EMIT: if (out_free) begin
        // hand the held item on and hold this one
        if (hold_r.vld) begin
          res_nxt = hold_r; oxy_nxt = hxy_r; oovf_nxt = ovf_r;
        end
        hold_nxt = '0; hold_nxt.vld = 1'b1; hold_nxt.cid = cid_r; hold_nxt.idx = 6'(cur_r);
        hxy_nxt = cur_xy_r;
        clus_nxt[cur_r] = 1'b1;
        st_nxt = S_CORE;
      end
      S_CORE: begin
        if (scan_busy) scan_nxt = scan_r + 1'b1;
        if (pp_r && near) nb_nxt = nb_r + 1'b1;
        if (scan_done) begin
          if (!is_core) begin
            if (mem_r) st_nxt = S_POP;
            else begin
              outer_nxt = outer_r + 1'b1; st_nxt = S_OUTER;
            end
          end else if (mem_r) begin
            scan_nxt = '0; st_nxt = S_NB;
          end else if (out_free) begin
            // seed a new cluster
            if (hold_r.vld) begin
              res_nxt = hold_r; oxy_nxt = hxy_r; oovf_nxt = ovf_r;
            end
            hold_nxt = '0; hold_nxt.vld = 1'b1; hold_nxt.cid = cid_r;
            hold_nxt.idx = 6'(cur_r);
            hxy_nxt = cur_xy_r;
            clus_nxt[cur_r] = 1'b1; qd_nxt[cur_r] = 1'b1;
            head_nxt = '0; tail_nxt = '0; scan_nxt = '0; st_nxt = S_NB;
          end
        end
      end
      S_NB: begin
        if (scan_busy) scan_nxt = scan_r + 1'b1;
        if (q_hit) begin
          qd_nxt[ppi_r] = 1'b1; tail_nxt = tail_r + 1'b1;
        end
        if (scan_done) st_nxt = S_POP;
      end
      S_POP: begin
        if (head_r < tail_r) st_nxt = S_POPRD;
        else begin
          // cluster done: flag the held item
          hold_nxt.eoc = 1'b1; cid_nxt = cid_r + 1'b1;
          outer_nxt = outer_r + 1'b1; st_nxt = S_OUTER;
        end
      end
      S_POPRD: begin
        head_nxt = head_r + 1'b1;
        if (clus_r[q_rd]) st_nxt = S_POP;
        else begin
          cur_nxt = q_rd; mem_nxt = 1'b1; st_nxt = S_RD;
        end
      end
      S_FIN: if (out_free) begin
        if (hold_r.vld) begin
          res_nxt = hold_r; res_nxt.eoa = 1'b1; oxy_nxt = hxy_r;
        end else begin
          res_nxt = '0; res_nxt.vld = 1'b1; res_nxt.eoa = 1'b1; res_nxt.none = 1'b1;
          oxy_nxt = '0;
        end
        oovf_nxt = ovf_r;
        hold_nxt = '0; clus_nxt = '0; qd_nxt = '0; cnt_nxt = '0; cid_nxt = '0;
        ovf_nxt = 1'b0; st_nxt = S_LOAD;
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0; cid_r <= '0; outer_r <= '0;
      cur_r <= '0; mem_r <= 1'b0; cur_xy_r <= '0; scan_r <= '0; nb_r <= '0;
      clus_r <= '0; qd_r <= '0; head_r <= '0; tail_r <= '0; hold_r <= '0;
      hxy_r <= '0; res_r <= '0; oxy_r <= '0; oovf_r <= 1'b0;
      p_r <= 1'b0; pp_r <= 1'b0; pi_r <= '0; ppi_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt; cid_r <= cid_nxt;
      outer_r <= outer_nxt; cur_r <= cur_nxt; mem_r <= mem_nxt; cur_xy_r <= cur_xy_nxt;
      scan_r <= scan_nxt; nb_r <= nb_nxt; clus_r <= clus_nxt; qd_r <= qd_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt; hold_r <= hold_nxt; hxy_r <= hxy_nxt;
      res_r <= res_nxt; oxy_r <= oxy_nxt; oovf_r <= oovf_nxt;
      p_r <= issue; pp_r <= p_r; pi_r <= scan_r[AW-1:0]; ppi_r <= pi_r;
    end
  end

  assign out_tvalid = res_r.vld;
  assign out_tdata  = OW'({oxy_r, res_r.idx, res_r.cid});
  assign out_tuser  = {oovf_r, res_r.none, res_r.eoc};
  assign out_tlast  = res_r.eoa;
endmodule
